FILE: rtl/core/ucs_pkg.sv
package ucs_pkg;

	// Longest URL taken before an overrun is flagged
	localparam int MAX_LEN = 4096;
	localparam int POS_W   = $clog2(MAX_LEN);
	localparam int CNT_W   = POS_W + 1;
	localparam int LEN_W   = 13;
	localparam int NPIECE  = 6;

	// Delimiter bytes
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;

	// Component open while parsing
	typedef enum logic [2:0] {
		COMP_SCHEME = 3'd0,
		COMP_USER   = 3'd1,
		COMP_PASS   = 3'd2,
		COMP_HOST   = 3'd3,
		COMP_PORT   = 3'd4,
		COMP_URI    = 3'd5
	} comp_t;

	// Kind of a result item
	typedef enum logic [2:0] {
		KIND_SCHEME   = 3'd0,
		KIND_USER     = 3'd1,
		KIND_PASS     = 3'd2,
		KIND_HOST     = 3'd3,
		KIND_PORT     = 3'd4,
		KIND_PATH     = 3'd5,
		KIND_QUERY    = 3'd6,
		KIND_FRAGMENT = 3'd7
	} kind_t;

	// Parse outcome of one URL, handed from parser to emitter
	typedef struct packed {
		comp_t                            open;
		logic [NPIECE-1:0][POS_W-1:0]     start;
		logic [NPIECE-1:0][LEN_W-1:0]     len;
		logic                             err;
		logic                             qf;
		logic [POS_W-1:0]                 qpos;
		logic                             ff;
		logic [POS_W-1:0]                 fpos;
	} frame_t;

endpackage

FILE: rtl/core/ucs_parser.sv
module ucs_parser
	import ucs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] url_byte,
	input  logic       last_byte,
	input  logic       frame_free,
	output logic       frame_load,
	output frame_t     frame
);

	typedef struct packed {
		frame_t            f;
		logic [NPIECE-1:0] started;
		logic              la;
		logic              held;
	} parse_state_t;

	localparam parse_state_t ST_IDLE = '0;

	function automatic parse_state_t move_piece(parse_state_t s, comp_t to, comp_t from);
		parse_state_t r;
		r = s;
		r.f.start[to]   = s.f.start[from];
		r.f.len[to]     = s.f.len[from];
		r.started[to]   = s.started[from];
		r.f.start[from] = '0;
		r.f.len[from]   = '0;
		r.started[from] = 1'b0;
		return r;
	endfunction

	function automatic parse_state_t plain_colon(parse_state_t s);
		parse_state_t r;
		r = move_piece(s, COMP_USER, COMP_SCHEME);
		r.f.open = COMP_PASS;
		return r;
	endfunction

	function automatic parse_state_t open_uri(parse_state_t s, logic [POS_W-1:0] pos);
		parse_state_t r;
		r = s;
		r.f.open            = COMP_URI;
		r.f.start[COMP_URI] = pos;
		r.f.len[COMP_URI]   = LEN_W'(1);
		r.started[COMP_URI] = 1'b1;
		return r;
	endfunction

	function automatic parse_state_t take_byte(parse_state_t s, logic [7:0] c,
			logic [POS_W-1:0] pos, logic last);
		parse_state_t r;
		r = s;
		priority if (c == CH_COLON) begin
			unique case (s.f.open)
				COMP_SCHEME: begin
					if (last) begin
						r = plain_colon(r);
					end else begin
						r.la   = 1'b1;
						r.held = 1'b0;
					end
				end
				COMP_USER: r.f.open = COMP_PASS;
				COMP_HOST: r.f.open = COMP_PORT;
				COMP_URI:  r.f.len[COMP_URI] = s.f.len[COMP_URI] + LEN_W'(1);
				default:   r.f.err = 1'b1;
			endcase
		end else if (c == CH_AT) begin
			unique case (s.f.open)
				COMP_SCHEME: begin
					r = move_piece(r, COMP_USER, COMP_SCHEME);
					r.f.open = COMP_HOST;
				end
				COMP_USER, COMP_PASS: r.f.open = COMP_HOST;
				COMP_URI: r.f.len[COMP_URI] = s.f.len[COMP_URI] + LEN_W'(1);
				default:  r.f.err = 1'b1;
			endcase
		end else if (c == CH_SLASH) begin
			unique case (s.f.open)
				COMP_SCHEME: begin
					if (s.f.len[COMP_SCHEME] == '0) begin
						r = open_uri(r, pos);
					end else begin
						r.f.err = 1'b1;
					end
				end
				COMP_HOST, COMP_PORT: r = open_uri(r, pos);
				COMP_USER: begin
					r = move_piece(r, COMP_HOST, COMP_USER);
					r = open_uri(r, pos);
				end
				COMP_PASS: begin
					r = move_piece(r, COMP_HOST, COMP_USER);
					r = move_piece(r, COMP_PORT, COMP_PASS);
					r = open_uri(r, pos);
				end
				COMP_URI: r.f.len[COMP_URI] = s.f.len[COMP_URI] + LEN_W'(1);
				default:  r.f.err = 1'b1;
			endcase
		end else begin
			// Ordinary byte: extend the open component
			for (int k = 0; k < NPIECE; k++) begin
				if (s.f.open == comp_t'(k)) begin
					if (!s.started[k]) begin
						r.started[k] = 1'b1;
						r.f.start[k] = pos;
					end
					r.f.len[k] = s.f.len[k] + LEN_W'(1);
				end
			end
			if (s.f.open == COMP_URI) begin
				if (c == CH_QUERY && !s.f.qf) begin
					r.f.qf   = 1'b1;
					r.f.qpos = pos;
				end
				if (c == CH_HASH && !s.f.ff) begin
					r.f.ff   = 1'b1;
					r.f.fpos = pos;
				end
			end
		end
		return r;
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             advance;
	parse_state_t     st_q;
	parse_state_t     st_n;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] pos_n;
	logic             ovf;
	logic [POS_W-1:0] pos;

	// A last byte waits in the input stage until the frame buffer is free
	assign advance    = valid_s1 && (!last_s1 || frame_free);
	assign in_ready   = !valid_s1 || advance;
	assign frame_load = valid_s1 && last_s1 && frame_free;
	assign frame      = st_n.f;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= url_byte;
			last_s1 <= last_byte;
		end
	end

	// Byte update, including the held colon and slash
	assign ovf = pos_q >= CNT_W'(MAX_LEN);
	assign pos = pos_q[POS_W-1:0];

	always_comb begin
		st_n       = st_q;
		st_n.f.err = st_q.f.err | ovf;
		if (!st_n.f.err) begin
			if (st_q.la && !st_q.held) begin
				if (byte_s1 == CH_SLASH && !last_s1) begin
					st_n.held = 1'b1;
				end else begin
					st_n.la = 1'b0;
					st_n    = plain_colon(st_n);
					st_n    = take_byte(st_n, byte_s1, pos, last_s1);
				end
			end else if (st_q.la) begin
				st_n.la   = 1'b0;
				st_n.held = 1'b0;
				if (byte_s1 == CH_SLASH) begin
					st_n.f.open = COMP_USER;
				end else begin
					// Colon and one slash were plain text: replay the slash
					st_n = plain_colon(st_n);
					st_n = take_byte(st_n, CH_SLASH, pos - POS_W'(1), 1'b0);
					if (!st_n.f.err) begin
						st_n = take_byte(st_n, byte_s1, pos, last_s1);
					end
				end
			end else begin
				st_n = take_byte(st_n, byte_s1, pos, last_s1);
			end
		end
		pos_n = ovf ? pos_q : pos_q + CNT_W'(1);
	end

	// Hold parse state; clear it once the last byte is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			pos_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				st_q  <= ST_IDLE;
				pos_q <= '0;
			end else begin
				st_q  <= st_n;
				pos_q <= pos_n;
			end
		end
	end

	a_held_needs_colon: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.held |-> st_q.la)
		else $error("slash held without a pending colon");

	a_colon_in_scheme: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.la |-> st_q.f.open == COMP_SCHEME)
		else $error("pending colon outside the scheme");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |=> (pos_q == '0 && !st_q.la && st_q.f.open == COMP_SCHEME))
		else $error("parse state not cleared after last byte");

endmodule

FILE: rtl/core/ucs_emitter.sv
module ucs_emitter
	import ucs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_load,
	input  frame_t           frame,
	output logic             frame_free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       comp_kind,
	output logic             comp_present,
	output logic [POS_W-1:0] comp_start,
	output logic [LEN_W-1:0] comp_length,
	output logic             parse_error,
	output logic             run_end
);

	frame_t            frame_q;
	logic              full_q;
	kind_t             idx_q;
	logic              out_valid_q;
	kind_t             kind_q;
	logic              present_q;
	logic [POS_W-1:0]  start_q;
	logic [LEN_W-1:0]  length_q;
	logic              error_q;
	logic              end_q;

	logic              load_out;
	logic              frame_done;
	logic [POS_W-1:0]  pc_start [5];
	logic [LEN_W-1:0]  pc_len [5];
	logic [LEN_W-1:0]  ue;
	logic              has;
	logic              q_ok;
	logic              f_ok;
	logic [LEN_W-1:0]  path_end;
	logic [POS_W-1:0]  r_start;
	logic [LEN_W-1:0]  r_minu;
	logic [LEN_W-1:0]  r_subt;
	logic [LEN_W-1:0]  r_len;
	logic              r_present;

	assign frame_free   = !full_q;
	assign load_out     = full_q && (!out_valid_q || out_ready);
	assign frame_done   = frame_q.err || idx_q == KIND_FRAGMENT;
	assign out_valid    = out_valid_q;
	assign comp_kind    = kind_q;
	assign comp_present = present_q;
	assign comp_start   = start_q;
	assign comp_length  = length_q;
	assign parse_error  = error_q;
	assign run_end      = end_q;

	// Apply end-of-string moves to the authority pieces
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			pc_start[k] = frame_q.start[k];
			pc_len[k]   = frame_q.len[k];
		end
		unique case (frame_q.open)
			COMP_SCHEME: begin
				if (frame_q.len[COMP_SCHEME] != '0) begin
					pc_start[COMP_HOST]   = frame_q.start[COMP_SCHEME];
					pc_len[COMP_HOST]     = frame_q.len[COMP_SCHEME];
					pc_start[COMP_SCHEME] = '0;
					pc_len[COMP_SCHEME]   = '0;
				end
			end
			COMP_USER: begin
				pc_start[COMP_HOST] = frame_q.start[COMP_USER];
				pc_len[COMP_HOST]   = frame_q.len[COMP_USER];
				pc_start[COMP_USER] = '0;
				pc_len[COMP_USER]   = '0;
			end
			COMP_PASS: begin
				pc_start[COMP_HOST] = frame_q.start[COMP_USER];
				pc_len[COMP_HOST]   = frame_q.len[COMP_USER];
				pc_start[COMP_PORT] = frame_q.start[COMP_PASS];
				pc_len[COMP_PORT]   = frame_q.len[COMP_PASS];
				pc_start[COMP_USER] = '0;
				pc_len[COMP_USER]   = '0;
				pc_start[COMP_PASS] = '0;
				pc_len[COMP_PASS]   = '0;
			end
			default: ;
		endcase
	end

	// Split the uri at its first '?' and '#'
	assign ue   = {1'b0, frame_q.start[COMP_URI]} + frame_q.len[COMP_URI];
	assign has  = frame_q.len[COMP_URI] != '0;
	assign f_ok = has && frame_q.ff;
	assign q_ok = has && frame_q.qf && !(frame_q.ff && frame_q.qpos > frame_q.fpos);
	assign path_end = q_ok ? {1'b0, frame_q.qpos} :
		f_ok ? {1'b0, frame_q.fpos} : ue;

	// Pick the fields of the result in turn
	always_comb begin
		r_start   = '0;
		r_minu    = '0;
		r_subt    = '0;
		r_present = 1'b0;
		unique case (idx_q)
			KIND_SCHEME, KIND_USER, KIND_PASS, KIND_HOST, KIND_PORT: begin
				r_start   = pc_start[idx_q];
				r_minu    = pc_len[idx_q];
				r_present = pc_len[idx_q] != '0;
			end
			KIND_PATH: begin
				r_start   = frame_q.start[COMP_URI];
				r_minu    = path_end;
				r_subt    = {1'b0, frame_q.start[COMP_URI]};
				r_present = has;
			end
			KIND_QUERY: begin
				r_subt    = {1'b0, frame_q.qpos} + LEN_W'(1);
				r_start   = r_subt[POS_W-1:0];
				r_minu    = f_ok ? {1'b0, frame_q.fpos} : ue;
				r_present = q_ok;
			end
			KIND_FRAGMENT: begin
				r_subt    = {1'b0, frame_q.fpos} + LEN_W'(1);
				r_start   = r_subt[POS_W-1:0];
				r_minu    = ue;
				r_present = f_ok;
			end
			default: ;
		endcase
		r_len = r_minu - r_subt;
	end

	// Frame buffer and result counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= 1'b0;
			idx_q       <= KIND_SCHEME;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_load) begin
				full_q <= 1'b1;
			end else if (load_out && frame_done) begin
				full_q <= 1'b0;
			end
			if (load_out) begin
				idx_q <= frame_done ? KIND_SCHEME : kind_t'(idx_q + 3'd1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame contents and result register
	always_ff @(posedge clk) begin
		if (frame_load) begin
			frame_q <= frame;
		end
		if (load_out) begin
			if (frame_q.err) begin
				kind_q    <= KIND_SCHEME;
				present_q <= 1'b0;
				start_q   <= '0;
				length_q  <= '0;
				error_q   <= 1'b1;
				end_q     <= 1'b1;
			end else begin
				kind_q    <= idx_q;
				present_q <= r_present;
				start_q   <= r_present ? r_start : '0;
				length_q  <= r_present ? r_len : '0;
				error_q   <= 1'b0;
				end_q     <= idx_q == KIND_FRAGMENT;
			end
		end
	end

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |-> !full_q)
		else $error("frame loaded over a busy buffer");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> (error_q || kind_q == KIND_FRAGMENT))
		else $error("run end on a result that is not the last");

	a_free_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && frame_done) |=> !full_q)
		else $error("frame buffer not released after its last result");

endmodule

FILE: rtl/core/url_component_splitter.sv
// Channel | Signals                                   | Moves
// in      | in_valid, in_ready, url_byte, last_byte   | one URL byte per item
// out     | out_valid, out_ready, comp_kind,          | one component per item
//         | comp_present, comp_start, comp_length,    |
//         | parse_error, run_end                      |
//
// One byte is taken per cycle, but a last byte stalls in the input stage while the
// frame buffer is full; the parse update sits between the input stage and the parse
// state registers. The last byte of a URL hands its outcome to a frame buffer, from
// which eight items (or one error item) leave at one per cycle as out_ready allows.
// Reset (arst_n low) empties both stages and returns the parse state to the scheme.
module url_component_splitter
	import ucs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       url_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       comp_kind,
	output logic             comp_present,
	output logic [POS_W-1:0] comp_start,
	output logic [LEN_W-1:0] comp_length,
	output logic             parse_error,
	output logic             run_end
);

	logic   frame_free;
	logic   frame_load;
	frame_t frame;

	ucs_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.url_byte   (url_byte),
		.last_byte  (last_byte),
		.frame_free (frame_free),
		.frame_load (frame_load),
		.frame      (frame)
	);

	ucs_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_load   (frame_load),
		.frame        (frame),
		.frame_free   (frame_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.comp_kind    (comp_kind),
		.comp_present (comp_present),
		.comp_start   (comp_start),
		.comp_length  (comp_length),
		.parse_error  (parse_error),
		.run_end      (run_end)
	);

endmodule
